FILE: hdl/irpt_pkg.sv
package irpt_pkg;

	// Function codes of a request
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [7:0] HALF_PERIOD_RESET = 8'd12;

	typedef struct packed {
		logic [1:0]  func;
		logic [6:0]  entry_index;
		logic [15:0] entry_duration;
	} irpt_item_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic done_res;
	} irpt_result_t;

endpackage

FILE: hdl/irpt_store.sv
// Pulse duration store: one write port, two registered read ports.
// A write in the same cycle as a read of that entry is forwarded.
module irpt_store #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [15:0]   rdata_a,
	output logic [15:0]   rdata_b
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_a_q;
	logic [15:0] rd_b_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, write-first on address match
	always_ff @(posedge clk) begin
		rd_a_q <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rd_b_q <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

	a_fwd_a: assert property (@(posedge clk) disable iff (!arst_n)
		(we && waddr == raddr_a) |=> (rdata_a == $past(wdata)))
		else $error("store: read port A missed a forwarded write");

	a_fwd_b: assert property (@(posedge clk) disable iff (!arst_n)
		(we && waddr == raddr_b) |=> (rdata_b == $past(wdata)))
		else $error("store: read port B missed a forwarded write");

	a_wr_known: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (!$isunknown(waddr) && !$isunknown(wdata)))
		else $error("store: write with unknown address or data");

endmodule

FILE: hdl/irpt_engine.sv
// Playback engine: carrier and interval counters, position, status flags.
// The store is addressed with the next position so that the entries for
// the current and the following position are ready when a tick arrives.
module irpt_engine #(
	parameter int unsigned MAX_PULSES = 128,
	parameter int unsigned AW         = 7,
	parameter int unsigned PW         = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  irpt_pkg::irpt_item_t  item,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic [15:0]           dur_cur,
	input  logic [15:0]           dur_nxt,
	output logic                  st_we,
	output logic [AW-1:0]         st_waddr,
	output logic [15:0]           st_wdata,
	output logic [AW-1:0]         st_raddr_a,
	output logic [AW-1:0]         st_raddr_b,
	output logic                  res_valid,
	output irpt_pkg::irpt_result_t res
);

	logic [PW-1:0] pos_q, pos_n;
	logic [PW:0]   pos_inc;
	logic [15:0]   ivl_q, ivl_n;
	logic [7:0]    car_cnt_q, car_cnt_n;
	logic          car_lvl_q, car_lvl_n;
	logic          gate_q, gate_n;
	logic          play_q, play_n;
	logic          fin_q, fin_n;
	logic [7:0]    half_q;
	logic          is_tick;
	logic [PW:0]   pos_adv;

	// Carrier half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= irpt_pkg::HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Load path to the store
	assign st_we    = accept && item.func == irpt_pkg::FUNC_LOAD
		&& 32'(item.entry_index) < 32'(MAX_PULSES);
	assign st_waddr = AW'(item.entry_index);
	assign st_wdata = item.entry_duration;

	assign is_tick = accept && item.func == irpt_pkg::FUNC_TICK && play_q;
	assign pos_adv = {1'b0, pos_q} + (PW+1)'(1);

	// Next state
	always_comb begin
		pos_n     = pos_q;
		ivl_n     = ivl_q;
		car_cnt_n = car_cnt_q;
		car_lvl_n = car_lvl_q;
		gate_n    = gate_q;
		play_n    = play_q;
		fin_n     = fin_q;
		if (accept) begin
			unique case (item.func)
				irpt_pkg::FUNC_START: begin
					pos_n  = '0;
					ivl_n  = '0;
					fin_n  = 1'b0;
					play_n = 1'b1;
					gate_n = 1'b1;
				end
				irpt_pkg::FUNC_TICK: begin
					if (is_tick) begin
						if (gate_q) begin
							if (car_cnt_q == half_q) begin
								car_cnt_n = '0;
								car_lvl_n = ~car_lvl_q;
							end else begin
								car_cnt_n = car_cnt_q + 8'd1;
							end
						end
						if (32'(pos_q) < 32'(MAX_PULSES) && ivl_q == dur_cur) begin
							ivl_n  = '0;
							gate_n = ~gate_q;
							pos_n  = PW'(pos_adv);
							if (32'(pos_adv) >= 32'(MAX_PULSES) || dur_nxt == 16'd0) begin
								play_n = 1'b0;
								gate_n = 1'b0;
								fin_n  = 1'b1;
							end
						end else begin
							ivl_n = ivl_q + 16'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Read addresses for the coming cycle; out-of-range slots are never used
	assign pos_inc    = {1'b0, pos_n} + (PW+1)'(1);
	assign st_raddr_a = (32'(pos_n) < 32'(MAX_PULSES)) ? AW'(pos_n) : '0;
	assign st_raddr_b = (32'(pos_inc) < 32'(MAX_PULSES)) ? AW'(pos_inc) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ivl_q     <= '0;
			car_cnt_q <= '0;
			car_lvl_q <= 1'b0;
			gate_q    <= 1'b0;
			play_q    <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			pos_q     <= pos_n;
			ivl_q     <= ivl_n;
			car_cnt_q <= car_cnt_n;
			car_lvl_q <= car_lvl_n;
			gate_q    <= gate_n;
			play_q    <= play_n;
			fin_q     <= fin_n;
		end
	end

	// One result per request, showing the state after it
	assign res_valid    = accept;
	assign res.ir_level = gate_n & car_lvl_n;
	assign res.busy_res = play_n;
	assign res.done_res = fin_n;

	a_gate_play: assert property (@(posedge clk) disable iff (!arst_n)
		gate_q |-> play_q)
		else $error("engine: carrier gated on while not playing");

	a_play_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!(play_q && fin_q))
		else $error("engine: playing and finished together");

	a_fin_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> $past(is_tick))
		else $error("engine: playback ended without a tick");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= 32'(MAX_PULSES))
		else $error("engine: position beyond the store");

endmodule

FILE: hdl/irpt_outq.sv
// Result register with a skid stage; stalls requests only when both are full.
module irpt_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  irpt_pkg::irpt_result_t in_data,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output irpt_pkg::irpt_result_t out_data
);

	logic                   main_v_q;
	logic                   skid_v_q;
	irpt_pkg::irpt_result_t main_q;
	irpt_pkg::irpt_result_t skid_q;
	logic                   main_free;

	assign main_free = !main_v_q || !out_stall;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			main_v_q <= skid_v_q || in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : in_data;
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	a_skid_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("outq: skid holds a result while the main stage is empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && skid_v_q))
		else $error("outq: result arrived while full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("outq: stalled result changed");

endmodule

FILE: hdl/ir_pulse_train_transmitter.sv
// Channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req (func, entry_index, entry_duration)
// result    | rsp_valid  | rsp_stall  | rsp (ir_level, busy_res, done_res)
// config    | cfg_we     | -          | cfg_wdata (carrier half period)
//
// One request per cycle while req_stall is low; its result is registered in the result register or its skid stage.
// The store is read each cycle at the next position and its successor, so a
// tick finds both durations ready; loads are forwarded into those reads.
// arst_n clears all control state; the store holds garbage until loaded.
// req_stall rises only when the result register and its skid stage are full.
module ir_pulse_train_transmitter #(
	parameter int unsigned MAX_PULSES = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  irpt_pkg::irpt_item_t   req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output irpt_pkg::irpt_result_t rsp,
	input  logic                   cfg_we,
	input  logic [7:0]             cfg_wdata
);

	localparam int unsigned AW = $clog2(MAX_PULSES);
	localparam int unsigned PW = $clog2(MAX_PULSES + 1);

	logic                   accept;
	logic                   st_we;
	logic [AW-1:0]          st_waddr;
	logic [15:0]            st_wdata;
	logic [AW-1:0]          st_raddr_a;
	logic [AW-1:0]          st_raddr_b;
	logic [15:0]            dur_cur;
	logic [15:0]            dur_nxt;
	logic                   res_valid;
	irpt_pkg::irpt_result_t res;

	assign accept = req_valid && !req_stall;

	irpt_store #(
		.DEPTH(MAX_PULSES),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (st_we),
		.waddr  (st_waddr),
		.wdata  (st_wdata),
		.raddr_a(st_raddr_a),
		.raddr_b(st_raddr_b),
		.rdata_a(dur_cur),
		.rdata_b(dur_nxt)
	);

	irpt_engine #(
		.MAX_PULSES(MAX_PULSES),
		.AW        (AW),
		.PW        (PW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.dur_cur   (dur_cur),
		.dur_nxt   (dur_nxt),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.st_raddr_a(st_raddr_a),
		.st_raddr_b(st_raddr_b),
		.res_valid (res_valid),
		.res       (res)
	);

	irpt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res),
		.full     (req_stall),
		.out_valid(rsp_valid),
		.out_stall(rsp_stall),
		.out_data (rsp)
	);

endmodule
